FILE: rtl/twlfs_pkg.sv
// Package for the two-wire LED frame serializer.
// Shared types, segment codes and sequencer constants; no dependencies.
package twlfs_pkg;

    localparam int COLOUR_W    = 8;
    localparam int QUEUE_DEPTH = 2;

    // Segment sequencer: step 0 is the start burst, 1..32 the bit pulses,
    // 33 the end burst.
    localparam int             STEP_W         = 6;
    localparam logic [STEP_W-1:0] STEP_START     = 6'd0;
    localparam logic [STEP_W-1:0] STEP_FIRST_BIT = 6'd1;
    localparam logic [STEP_W-1:0] STEP_END       = 6'd33;

    localparam logic [2:0] LOW_SHORT = 3'd1;
    localparam logic [2:0] LOW_LONG  = 3'd4;
    localparam logic [1:0] TAIL_NONE = 2'd0;
    localparam logic [1:0] TAIL_BYTE = 2'd3;

    typedef enum logic [1:0] {
        SEG_BIT   = 2'd0,
        SEG_START = 2'd1,
        SEG_END   = 2'd2
    } t_seg_kind;

    // One classified LED waiting for the back end.
    typedef struct packed {
        logic                    need_start;
        logic                    need_end;
        logic [COLOUR_W-1:0]     header;
        logic [3*COLOUR_W-1:0]   colour;   // red in the top byte
    } t_pix_entry;

    typedef struct packed {
        t_seg_kind  kind;
        logic       data_level;
        logic [2:0] low_quanta;
        logic [1:0] tail_quanta;
        logic       last_result;
    } t_segment;

endpackage

FILE: rtl/twlfs_front.sv
// Front end: takes LED beats, tracks the open frame, tags start/end bursts.
// Depends on twlfs_pkg.
module twlfs_front
    import twlfs_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [COLOUR_W-1:0]   i_cfg_wdata,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [3*COLOUR_W-1:0] s_axis_tdata,   // red, green, blue
    input  logic                  s_axis_tlast,   // last_pixel
    input  logic                  i_q_full,
    output logic                  o_q_push,
    output t_pix_entry            o_q_entry
);

    logic                r_frame_open;
    logic [COLOUR_W-1:0] r_header;

    assign s_axis_tready = !i_q_full;
    assign o_q_push      = s_axis_tvalid && !i_q_full;

    always_comb begin
        o_q_entry.need_start = !r_frame_open;
        o_q_entry.need_end   = s_axis_tlast;
        o_q_entry.header     = r_header;
        o_q_entry.colour     = {s_axis_tdata[COLOUR_W-1:0],
                                s_axis_tdata[2*COLOUR_W-1:COLOUR_W],
                                s_axis_tdata[3*COLOUR_W-1:2*COLOUR_W]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_open <= 1'b0;
            r_header     <= '0;
        end else begin
            if (i_cfg_we) begin
                r_header <= i_cfg_wdata;
            end
            if (o_q_push) begin
                r_frame_open <= !s_axis_tlast;
            end
        end
    end

endmodule

FILE: rtl/twlfs_queue.sv
// Small queue of classified LEDs between front and back end.
// Depends on twlfs_pkg.
module twlfs_queue
    import twlfs_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    input  t_pix_entry i_entry,
    output logic       o_full,
    input  logic       i_pop,
    output logic       o_valid,
    output t_pix_entry o_head
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    t_pix_entry       r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic [PTR_W-1:0] n_wr_ptr, n_rd_ptr;
    logic [CNT_W-1:0] n_count;

    assign o_full  = (r_count == CNT_FULL);
    assign o_valid = (r_count != '0);
    assign o_head  = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full || i_pop)
        else $error("queue push while full");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid)
        else $error("queue pop while empty");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_FULL)
        else $error("queue count out of range");

endmodule

FILE: rtl/twlfs_back.sv
// Back end: walks each queued LED through its segments, one per beat,
// into a registered output stage. Depends on twlfs_pkg.
module twlfs_back
    import twlfs_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_q_valid,
    input  t_pix_entry i_q_head,
    output logic       o_q_pop,
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // data_level, low_quanta[2:0], tail_quanta[1:0], 2'b0
    output logic [1:0] m_axis_tuser,   // segment_kind
    output logic       m_axis_tlast    // last_result
);

    logic [STEP_W-1:0]        r_step, n_step, eff_step;
    logic [4:0]               bit_idx;
    logic [4*COLOUR_W-1:0]    word;
    logic                     adv, emit;
    t_segment                 seg;
    t_segment                 r_seg;
    logic                     r_valid;

    assign adv  = !r_valid || m_axis_tready;
    assign emit = adv && i_q_valid;

    always_comb begin
        // frames already open skip the start burst step
        eff_step = (r_step == STEP_START && !i_q_head.need_start) ? STEP_FIRST_BIT : r_step;
        bit_idx  = 5'(eff_step - STEP_FIRST_BIT);
        word     = {i_q_head.header, i_q_head.colour};

        seg.kind        = SEG_BIT;
        seg.data_level  = 1'b0;
        seg.low_quanta  = 3'd0;
        seg.tail_quanta = TAIL_NONE;
        seg.last_result = 1'b0;
        if (eff_step == STEP_START) begin
            seg.kind = SEG_START;
        end else if (eff_step == STEP_END) begin
            seg.kind        = SEG_END;
            seg.last_result = 1'b1;
        end else begin
            seg.data_level = word[~bit_idx];
            // header bits alternate short and long clock-low
            seg.low_quanta = (bit_idx < 5'd8 && bit_idx[0]) ? LOW_LONG : LOW_SHORT;
            if (bit_idx >= 5'd8 && bit_idx[2:0] == 3'd7) begin
                seg.tail_quanta = TAIL_BYTE;
            end
            seg.last_result = (bit_idx == 5'd31) && !i_q_head.need_end;
        end
    end

    always_comb begin
        n_step = r_step;
        if (emit) begin
            n_step = seg.last_result ? STEP_START : eff_step + 1'b1;
        end
    end

    assign o_q_pop = emit && seg.last_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step  <= STEP_START;
            r_valid <= 1'b0;
        end else begin
            r_step <= n_step;
            if (adv) begin
                r_valid <= i_q_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_seg <= seg;
        end
    end

    assign m_axis_tvalid = r_valid;
    assign m_axis_tdata  = {2'b00, r_seg.tail_quanta, r_seg.low_quanta, r_seg.data_level};
    assign m_axis_tuser  = r_seg.kind;
    assign m_axis_tlast  = r_seg.last_result;

    a_step_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_step <= STEP_END)
        else $error("segment step out of range");

    a_idle_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_q_valid |-> r_step == STEP_START)
        else $error("sequencer mid-LED with empty queue");

    a_end_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser == SEG_END |-> m_axis_tlast)
        else $error("end burst not marked last");

    a_start_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser == SEG_START |-> !m_axis_tlast)
        else $error("start burst marked last");

endmodule

FILE: rtl/two_wire_led_frame_serializer.sv
// Two-wire LED frame serializer: each LED beat becomes 32 bit-pulse segments,
// plus a start burst on the first LED of a frame and an end burst on the last.
// The LED beat is written into the queue, then its segments into the registered output.
// Throughput: one segment per cycle while the receiver is ready (32 per LED, 33 or 34
// with bursts), set by the back-end sequencer; a 2-deep queue hides the front end.
// Reset (synchronous, active low) closes the frame and clears header_byte to 0.
module two_wire_led_frame_serializer
    import twlfs_pkg::*;
#(
    parameter int QDEPTH = QUEUE_DEPTH
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [COLOUR_W-1:0]   i_cfg_wdata,    // header_byte
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [3*COLOUR_W-1:0] s_axis_tdata,   // red[7:0], green[7:0], blue[7:0]
    input  logic                  s_axis_tlast,   // last_pixel
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [7:0]            m_axis_tdata,   // data_level, low_quanta[2:0], tail_quanta[1:0], pad
    output logic [1:0]            m_axis_tuser,   // segment_kind
    output logic                  m_axis_tlast    // last_result
);

    logic       q_push, q_full, q_pop, q_valid;
    t_pix_entry q_in, q_head;

    twlfs_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .i_q_full      (q_full),
        .o_q_push      (q_push),
        .o_q_entry     (q_in)
    );

    twlfs_queue #(
        .DEPTH (QDEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_entry (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_head  (q_head)
    );

    twlfs_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_valid     (q_valid),
        .i_q_head      (q_head),
        .o_q_pop       (q_pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

FILE: bench/tb_top.sv
// Testbench for two_wire_led_frame_serializer: drives LED beats, predicts the
// start/bit/end segment stream and checks each output beat. Depends on twlfs_pkg.
module tb_top;
    import twlfs_pkg::*;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [COLOUR_W-1:0]   i_cfg_wdata;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [3*COLOUR_W-1:0] s_axis_tdata;   // red[7:0], green[7:0], blue[7:0]
    logic                  s_axis_tlast;   // last_pixel
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [7:0]            m_axis_tdata;   // data_level, low_quanta[2:0], tail_quanta[1:0], pad
    logic [1:0]            m_axis_tuser;   // segment_kind
    logic                  m_axis_tlast;   // last_result

    two_wire_led_frame_serializer dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // Shadow of the block's state and register
    logic [7:0] header_shadow;
    logic       frame_open_shadow;
    t_segment   pending_segments[$];
    int         n_errors;
    int         rx_hold_cycles;
    bit         no_gaps;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("tb_top: errors");
        $finish;
    end

    function automatic void push_segment(input t_seg_kind kind, input logic data_level,
                                         input logic [2:0] lowq, input logic [1:0] tailq,
                                         input logic last_result);
        t_segment seg;
        seg.kind        = kind;
        seg.data_level  = data_level;
        seg.low_quanta  = lowq;
        seg.tail_quanta = tailq;
        seg.last_result = last_result;
        pending_segments.push_back(seg);
    endfunction

    function automatic void predict_led_segments(input logic [7:0] red, input logic [7:0] green,
                                                 input logic [7:0] blue, input logic last_pixel);
        logic [23:0] colours;
        colours = {red, green, blue};
        if (!frame_open_shadow) begin
            push_segment(SEG_START, 1'b0, 3'd0, 2'd0, 1'b0);
            frame_open_shadow = 1'b1;
        end
        // header bits: clock-low alternates short/long
        for (int b = 0; b < 8; b++)
            push_segment(SEG_BIT, header_shadow[7-b], (b % 2) ? LOW_LONG : LOW_SHORT,
                         TAIL_NONE, 1'b0);
        for (int b = 23; b >= 0; b--)
            push_segment(SEG_BIT, colours[b], LOW_SHORT, (b % 8 == 0) ? TAIL_BYTE : TAIL_NONE,
                         (b == 0) && !last_pixel);
        if (last_pixel) begin
            push_segment(SEG_END, 1'b0, 3'd0, 2'd0, 1'b1);
            frame_open_shadow = 1'b0;
        end
    endfunction

    // Called at a rising edge; returns at the edge where the beat was taken.
    task automatic send_led(input logic [7:0] red, input logic [7:0] green,
                            input logic [7:0] blue, input logic last_pixel);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 3);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {blue, green, red};
        s_axis_tlast  <= last_pixel;
        do @(posedge i_clk); while (!s_axis_tready);
        predict_led_segments(red, green, blue, last_pixel);
    endtask

    task automatic send_random_led(input logic last_pixel);
        send_led(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                 8'($urandom_range(0, 255)), last_pixel);
    endtask

    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (pending_segments.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_header(input logic [7:0] value);
        wait_idle();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        header_shadow = value;
    endtask

    // header still at its reset value of zero
    task automatic test_reset_header();
        send_led(8'h00, 8'h00, 8'h00, 1'b1);
        send_led(8'hFF, 8'hFF, 8'hFF, 1'b1);
    endtask

    task automatic test_header_values();
        write_header(8'hFF);
        send_led(8'h12, 8'h34, 8'h56, 1'b1);
        send_led(8'h80, 8'h01, 8'h7F, 1'b0);
        send_led(8'hFE, 8'h00, 8'hFF, 1'b1);
        write_header(8'hA5);
        send_led(8'h55, 8'hAA, 8'h55, 1'b0);
        send_led(8'hAA, 8'h55, 8'hAA, 1'b1);
        write_header(8'h5A);
        send_led(8'h01, 8'h80, 8'h01, 1'b1);
    endtask

    // frame left open across a register write, then closed
    task automatic test_colour_extremes();
        send_led(8'hFF, 8'h00, 8'h00, 1'b0);
        send_led(8'h00, 8'hFF, 8'h00, 1'b0);
        write_header(8'h00);
        send_led(8'h00, 8'h00, 8'hFF, 1'b0);
        send_led(8'hFF, 8'hFF, 8'hFF, 1'b0);
        send_led(8'h00, 8'h00, 8'h00, 1'b1);
    endtask

    task automatic test_back_to_back();
        write_header(8'hC3);
        no_gaps = 1'b1;
        repeat (3) send_random_led(1'b0);
        send_random_led(1'b1);
        wait_idle();
        no_gaps = 1'b0;
    endtask

    // receiver stalls long while the sender keeps offering beats
    task automatic test_output_stall();
        rx_hold_cycles = 150;
        repeat (4) send_random_led(1'b0);
        send_random_led(1'b1);
        wait_idle();
    endtask

    task automatic test_random_frames();
        int items;
        int frame_len;
        int phase;
        logic [7:0] hdr;
        items = 0;
        phase = 0;
        while (items < 158) begin
            if (items >= phase * 40) begin
                case (phase % 4)
                    0: hdr = 8'hFF;
                    1: hdr = 8'h00;
                    default: hdr = 8'($urandom_range(0, 255));
                endcase
                write_header(hdr);
                no_gaps = (phase == 2);
                phase++;
            end
            frame_len = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 14)
                                                     : $urandom_range(1, 5);
            for (int i = 0; i < frame_len; i++) begin
                // now and then the frame end is random rather than at the count
                if ($urandom_range(0, 7) == 0)
                    send_random_led(1'($urandom_range(0, 1)));
                else
                    send_random_led(i == frame_len - 1);
                items++;
            end
        end
        no_gaps = 1'b0;
    endtask

    // Receiver: ready pattern per beat
    initial begin
        int stall;
        m_axis_tready = 1'b0;
        forever begin
            stall = no_gaps ? 0 : $urandom_range(0, 3);
            if (rx_hold_cycles > 0) begin
                stall = rx_hold_cycles;
                rx_hold_cycles = 0;
            end
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
        end
    end

    always @(posedge i_clk) begin
        t_segment want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_segments.size() == 0) begin
                n_errors++;
                $error("unexpected segment beat: kind %0d data 0x%02h",
                       m_axis_tuser, m_axis_tdata);
            end else begin
                want = pending_segments.pop_front();
                if (m_axis_tuser !== want.kind) begin
                    n_errors++;
                    $error("segment_kind: expected %0d, got %0d", want.kind, m_axis_tuser);
                end
                if (m_axis_tdata[0] !== want.data_level) begin
                    n_errors++;
                    $error("data_level: expected %0d, got %0d",
                           want.data_level, m_axis_tdata[0]);
                end
                if (m_axis_tdata[3:1] !== want.low_quanta) begin
                    n_errors++;
                    $error("low_quanta: expected %0d, got %0d",
                           want.low_quanta, m_axis_tdata[3:1]);
                end
                if (m_axis_tdata[5:4] !== want.tail_quanta) begin
                    n_errors++;
                    $error("tail_quanta: expected %0d, got %0d",
                           want.tail_quanta, m_axis_tdata[5:4]);
                end
                if (m_axis_tlast !== want.last_result) begin
                    n_errors++;
                    $error("last_result: expected %0d, got %0d",
                           want.last_result, m_axis_tlast);
                end
            end
        end
    end

    initial begin
        n_errors          = 0;
        rx_hold_cycles    = 0;
        no_gaps           = 1'b0;
        header_shadow     = 8'h00;
        frame_open_shadow = 1'b0;
        i_rst_n           = 1'b0;
        i_cfg_we          = 1'b0;
        i_cfg_wdata       = '0;
        s_axis_tvalid     = 1'b0;
        s_axis_tdata      = '0;
        s_axis_tlast      = 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_header();
        test_header_values();
        test_colour_extremes();
        test_back_to_back();
        test_output_stall();
        test_random_frames();

        wait_idle();
        repeat (10) @(posedge i_clk);
        if (n_errors == 0 && pending_segments.size() == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

endmodule
